/* hw/rtl/tiled_nibble_pixel_access_unit_defines.svh */
// Assertion macros shared by the pixel access unit.
// Needs no other file; define ASSERT_OFF to drop every check.
`ifndef TILED_NIBBLE_PIXEL_ACCESS_UNIT_DEFINES_SVH
`define TILED_NIBBLE_PIXEL_ACCESS_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TNPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define TNPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TNPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TNPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/tnpa_pkg.sv */
// Shared types and codes of the tiled nibble pixel access unit.
// No dependencies.
`default_nettype none
package tnpa_pkg;

  // action codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // tile ordering codes
  localparam logic ORDER_ROW = 1'b0;
  localparam logic ORDER_COL = 1'b1;

  // request queue between address front and memory back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // one classified access, address already reduced to the memory size
  typedef struct packed {
    logic        action;
    logic        hi_nib;
    logic [3:0]  color;
    logic [15:0] addr;
  } req_t;

endpackage
`default_nettype wire

/* hw/rtl/tnpa_front.sv */
// Address front: accepts pixel requests and works out the byte address.
// Depends on tnpa_pkg.
`default_nettype none
module tnpa_front #(
  parameter int unsigned VRAM_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic         in_action,
  input  wire logic         in_tile_order,
  input  wire logic [15:0]  in_base_offset,
  input  wire logic [7:0]   in_width_tiles,
  input  wire logic [7:0]   in_height_tiles,
  input  wire logic [11:0]  in_pixel_x,
  input  wire logic [10:0]  in_pixel_y,
  input  wire logic [3:0]   in_color,
  output logic              q_push,
  input  wire logic         q_full,
  output tnpa_pkg::req_t    q_data
);

  // reciprocal of the memory size, scaled by 2^32, rounded up
  localparam logic [63:0] RECIP = ((64'd1 << 32) + 64'(VRAM_BYTES) - 64'd1) / 64'(VRAM_BYTES);
  localparam logic [16:0] VB    = 17'(VRAM_BYTES);

  typedef enum logic [2:0] {
    F_IDLE, F_TILE, F_ADDR, F_RCP, F_RED, F_PUSH
  } fstate_t;

  fstate_t        state_r;
  logic           act_r, ord_r, hi_r;
  logic [15:0]    base_r;
  logic [7:0]     wt_r, ht_r;
  logic [11:0]    x_r;
  logic [10:0]    y_r;
  logic [3:0]     col_r;
  logic [15:0]    tile_r;
  logic [2:0]     px_r, py_r;
  logic [15:0]    addr_r;
  logic [15:0]    quo_r;
  tnpa_pkg::req_t req_r;

  logic [10:0] wpix;
  logic [11:0] xa;
  logic [7:0]  tx, ty;
  logic [16:0] tile_sum;
  logic [15:0] addr_sum;
  logic [47:0] rcp_prod;
  logic [32:0] qv;
  logic [16:0] rem0, rem1;

  // tile coordinates and tile index
  always_comb begin
    wpix = {wt_r, 3'b000};
    xa   = (x_r > {1'b0, wpix}) ? (x_r - {1'b0, wpix}) : x_r;
    tx   = xa[10:3];
    ty   = y_r[10:3];
    if (ord_r == tnpa_pkg::ORDER_ROW) begin
      tile_sum = 17'({8'd0, ty} * {8'd0, wt_r}) + {9'd0, tx};
    end else begin
      tile_sum = 17'({8'd0, tx} * {8'd0, ht_r}) + {9'd0, ty};
    end
  end

  // byte address and its reduction by the memory size
  always_comb begin
    addr_sum = base_r + {tile_r[10:0], 5'b00000} + {11'd0, py_r, 2'b00}
             + {14'd0, px_r[2:1]};
    rcp_prod = {32'd0, addr_r} * {16'd0, RECIP[31:0]};
    qv       = 33'({17'd0, quo_r} * {16'd0, VB});
    rem0     = {1'b0, addr_r} - qv[16:0];
    rem1     = (rem0 >= VB) ? (rem0 - VB) : rem0;
  end

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_data  = req_r;

  // sequencer: one request at a time through the address steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            act_r   <= in_action;
            ord_r   <= in_tile_order;
            base_r  <= in_base_offset;
            wt_r    <= in_width_tiles;
            ht_r    <= in_height_tiles;
            x_r     <= in_pixel_x;
            y_r     <= in_pixel_y;
            col_r   <= in_color;
            state_r <= F_TILE;
          end
        end
        F_TILE: begin
          tile_r  <= tile_sum[15:0];
          px_r    <= xa[2:0];
          py_r    <= y_r[2:0];
          hi_r    <= ~xa[0];
          state_r <= F_ADDR;
        end
        F_ADDR: begin
          addr_r  <= addr_sum;
          state_r <= F_RCP;
        end
        F_RCP: begin
          quo_r   <= rcp_prod[47:32];
          state_r <= F_RED;
        end
        F_RED: begin
          req_r.action <= act_r;
          req_r.hi_nib <= hi_r;
          req_r.color  <= col_r;
          req_r.addr   <= rem1[15:0];
          state_r      <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tnpa_queue.sv */
// Short request queue between the address front and the memory back.
// Depends on tnpa_pkg.
`default_nettype none
module tnpa_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire tnpa_pkg::req_t  wr_data,
  input  wire logic            pop,
  output logic                 empty,
  output tnpa_pkg::req_t       rd_data
);

  tnpa_pkg::req_t                 slot_r [tnpa_pkg::QDEPTH];
  logic [tnpa_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [tnpa_pkg::QCNT_W-1:0]    cnt_r;
  logic                           do_push, do_pop;

  assign full    = (cnt_r == tnpa_pkg::QCNT_W'(tnpa_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tnpa_back.sv */
// Memory back: reads the addressed byte, merges a written nibble, returns results.
// Depends on tnpa_pkg; holds the video memory.
`default_nettype none
module tnpa_back #(
  parameter int unsigned VRAM_BYTES = 65536
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  output logic                 q_pop,
  input  wire logic            q_empty,
  input  wire tnpa_pkg::req_t  q_data,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [3:0]           out_read_color
);

  localparam int unsigned AW = (VRAM_BYTES > 1) ? $clog2(VRAM_BYTES) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(VRAM_BYTES - 1);

  typedef enum logic [1:0] {
    B_CLR, B_IDLE, B_MOD
  } bstate_t;

  bstate_t        state_r;
  logic [7:0]     vram [VRAM_BYTES];
  logic [7:0]     rd_r;
  tnpa_pkg::req_t cur_r;
  logic           out_vld_r;
  logic [3:0]     out_color_r;
  logic [AW-1:0]  clr_addr_r;

  logic           slot_free;
  logic           wr_en;
  logic [7:0]     wr_byte;
  logic [3:0]     nib;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [7:0]     mem_wdata;

  assign out_empty      = !out_vld_r;
  assign out_read_color = out_color_r;
  assign slot_free      = !out_vld_r || out_pop;
  assign q_pop          = (state_r == B_IDLE) && !q_empty && slot_free;
  assign wr_en          = (state_r == B_MOD) && (cur_r.action == tnpa_pkg::ACT_WRITE);
  assign mem_we         = wr_en || (state_r == B_CLR);

  // merge the new nibble and pick the nibble to return
  always_comb begin
    if (cur_r.hi_nib) begin
      wr_byte = {cur_r.color, rd_r[3:0]};
      nib     = rd_r[7:4];
    end else begin
      wr_byte = {rd_r[7:4], cur_r.color};
      nib     = rd_r[3:0];
    end
  end

  // write zeros during the clear pass, otherwise write back the merged byte
  always_comb begin
    if (state_r == B_CLR) begin
      mem_addr  = clr_addr_r;
      mem_wdata = 8'h00;
    end else begin
      mem_addr  = cur_r.addr[AW-1:0];
      mem_wdata = wr_byte;
    end
  end

  // video memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= vram[q_data.addr[AW-1:0]];
    end
    if (mem_we) begin
      vram[mem_addr] <= mem_wdata;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLR;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        B_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == CLR_LAST) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_data;
            state_r <= B_MOD;
          end
        end
        B_MOD: begin
          out_color_r <= (cur_r.action == tnpa_pkg::ACT_WRITE) ? 4'h0 : nib;
          out_vld_r   <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tiled_nibble_pixel_access_unit.sv */
// Top level of the tiled nibble pixel access unit.
// Depends on tnpa_pkg, tnpa_front, tnpa_queue, tnpa_back and the defines header.
//
//   channel   direction  handshake        payload
//   in_*      input      push / full      action, tile_order, base_offset, width_tiles,
//                                         height_tiles, pixel_x, pixel_y, color
//   out_*     output     empty / pop      read_color
//
// The front works on one request at a time (tile index, byte address, reciprocal
// multiply, size reduction, push); the back on one too (registered read, merge/write).
// After reset the back zeroes all VRAM_BYTES bytes of video memory (65536 by
// default), one byte a cycle, and pops no request until it is done.
// A four-entry queue parts front and back; a held result stops the back, and once the
// queue fills the front holds in its push step with in_full high.
`default_nettype none
`include "tiled_nibble_pixel_access_unit_defines.svh"
module tiled_nibble_pixel_access_unit #(
  parameter int unsigned VRAM_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic         in_action,
  input  wire logic         in_tile_order,
  input  wire logic [15:0]  in_base_offset,
  input  wire logic [7:0]   in_width_tiles,
  input  wire logic [7:0]   in_height_tiles,
  input  wire logic [11:0]  in_pixel_x,
  input  wire logic [10:0]  in_pixel_y,
  input  wire logic [3:0]   in_color,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [3:0]        out_read_color
);

  logic           q_push, q_full, q_pop, q_empty;
  tnpa_pkg::req_t q_wr, q_rd;

  // classify and address
  tnpa_front #(.VRAM_BYTES(VRAM_BYTES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_tile_order   (in_tile_order),
    .in_base_offset  (in_base_offset),
    .in_width_tiles  (in_width_tiles),
    .in_height_tiles (in_height_tiles),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_color        (in_color),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_data          (q_wr)
  );

  // decouple front and back
  tnpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  // memory access and results
  tnpa_back #(.VRAM_BYTES(VRAM_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_data         (q_rd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_read_color (out_read_color)
  );

  // checks
  `TNPA_ASSERT_NEXT(a_front_busy, clk, rst_n, in_push && !in_full, in_full)
  `TNPA_ASSERT_IMPL(a_push_room, clk, rst_n, q_push, !q_full)
  `TNPA_ASSERT_IMPL(a_back_slot, clk, rst_n, q_pop, out_empty || out_pop)
  `TNPA_ASSERT_NEXT(a_result_follows, clk, rst_n, q_pop, !q_pop)

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench for the tiled nibble pixel access unit: directed pixel reads and writes,
// then random object scenes, checked against a bit-accurate predictor or typed colors.
// Depends on tnpa_pkg and the tiled_nibble_pixel_access_unit RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic ACT_READ  = tnpa_pkg::ACT_READ;
  localparam logic ACT_WRITE = tnpa_pkg::ACT_WRITE;
  localparam logic ORDER_ROW = tnpa_pkg::ORDER_ROW;
  localparam logic ORDER_COL = tnpa_pkg::ORDER_COL;

  localparam int unsigned VRAM_BYTES    = 65536;
  localparam int unsigned TOTAL_ITEMS   = 1900;
  localparam int unsigned HOLDOFF_LEN   = 400;
  // the memory clear after reset is the longest stretch without a transfer
  localparam int unsigned STALL_LIMIT   = 4 * (VRAM_BYTES + HOLDOFF_LEN);
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned HISTORY_DEPTH = 512;
  localparam int          DIRECTED_ROWS = 21;

  typedef struct packed {
    logic        action;
    logic        tile_order;
    logic [15:0] base_offset;
    logic [7:0]  width_tiles;
    logic [7:0]  height_tiles;
    logic [11:0] pixel_x;
    logic [10:0] pixel_y;
    logic [3:0]  color;
  } pixel_op_t;

  typedef struct packed {
    pixel_op_t  op;
    logic       typed;
    logic [3:0] color;
  } pixel_row_t;

  typedef struct {
    int unsigned seq;
    logic [3:0]  color;
  } pixel_expect_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_action;
  logic        in_tile_order;
  logic [15:0] in_base_offset;
  logic [7:0]  in_width_tiles;
  logic [7:0]  in_height_tiles;
  logic [11:0] in_pixel_x;
  logic [10:0] in_pixel_y;
  logic [3:0]  in_color;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_read_color;

  // shadow video memory and which nibbles have been written
  logic [7:0]    vram_shadow [VRAM_BYTES];
  bit            nibble_written [2 * VRAM_BYTES];
  pixel_expect_t expected_colors [$];
  pixel_op_t     written_ops [$];
  pixel_expect_t oldest;

  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned holdoff_count = 0;
  bit          calm = 1'b0;
  bit          holdoff_go = 1'b0;

  // directed rows: extremes, zero sizes, wrap-around, x subtraction, same-byte pairs
  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{ACT_WRITE, ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h000, 11'h000, 4'hF}, 1'b1, 4'h0},
    '{'{ACT_WRITE, ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h001, 11'h000, 4'h0}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h000, 11'h000, 4'h0}, 1'b1, 4'hF},
    '{'{ACT_READ,  ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h001, 11'h000, 4'hF}, 1'b1, 4'h0},
    '{'{ACT_WRITE, ORDER_COL, 16'hFFFF, 8'hFF, 8'hFF, 12'hFFF, 11'h7FF, 4'hA}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_COL, 16'hFFFF, 8'hFF, 8'hFF, 12'hFFF, 11'h7FF, 4'h0}, 1'b1, 4'hA},
    '{'{ACT_WRITE, ORDER_ROW, 16'hFFFF, 8'hFF, 8'h00, 12'hFFF, 11'h7FF, 4'h5}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'hFFFF, 8'hFF, 8'h00, 12'hFFF, 11'h7FF, 4'h0}, 1'b1, 4'h5},
    '{'{ACT_WRITE, ORDER_ROW, 16'h0100, 8'h00, 8'hFF, 12'hFFF, 11'h000, 4'hC}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'h0100, 8'h00, 8'hFF, 12'hFFF, 11'h000, 4'h0}, 1'b1, 4'hC},
    '{'{ACT_WRITE, ORDER_ROW, 16'h0800, 8'h0A, 8'h01, 12'h050, 11'h000, 4'h3}, 1'b1, 4'h0},
    '{'{ACT_WRITE, ORDER_ROW, 16'h0800, 8'h0A, 8'h01, 12'h051, 11'h000, 4'h9}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'h0800, 8'h0A, 8'h01, 12'h050, 11'h000, 4'h0}, 1'b1, 4'h3},
    '{'{ACT_READ,  ORDER_ROW, 16'h0800, 8'h0A, 8'h01, 12'h051, 11'h000, 4'h0}, 1'b1, 4'h9},
    '{'{ACT_WRITE, ORDER_COL, 16'h2000, 8'h03, 8'h00, 12'h011, 11'h009, 4'h7}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_COL, 16'h2000, 8'h03, 8'h00, 12'h011, 11'h009, 4'h0}, 1'b0, 4'h0},
    '{'{ACT_WRITE, ORDER_COL, 16'h1234, 8'h04, 8'h06, 12'h00D, 11'h015, 4'hE}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_COL, 16'h1234, 8'h04, 8'h06, 12'h00D, 11'h015, 4'h0}, 1'b0, 4'h0},
    '{'{ACT_WRITE, ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h000, 11'h000, 4'h0}, 1'b1, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h000, 11'h000, 4'h0}, 1'b0, 4'h0},
    '{'{ACT_READ,  ORDER_ROW, 16'h0000, 8'h00, 8'h00, 12'h001, 11'h000, 4'h0}, 1'b0, 4'h0}
  };

  tiled_nibble_pixel_access_unit #(
    .VRAM_BYTES(VRAM_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_tile_order  (in_tile_order),
    .in_base_offset (in_base_offset),
    .in_width_tiles (in_width_tiles),
    .in_height_tiles(in_height_tiles),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_color       (in_color),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_read_color (out_read_color)
  );

  always #5 clk = ~clk;

  // Map a pixel to its byte address and nibble half.
  function automatic void locate_pixel(input pixel_op_t op, output logic [15:0] addr,
                                       output logic hi);
    logic [31:0] x, wpix, tx, ty, tile, sum;
    wpix = 32'(op.width_tiles) * 32'd8;
    x    = 32'(op.pixel_x);
    if (x > wpix) x = x - wpix;
    tx = (x >> 3) & 32'hFF;
    ty = (32'(op.pixel_y) >> 3) & 32'hFF;
    if (op.tile_order == ORDER_ROW) tile = (ty * 32'(op.width_tiles) + tx) & 32'hFFFF;
    else tile = (tx * 32'(op.height_tiles) + ty) & 32'hFFFF;
    sum = (32'(op.base_offset) + ((tile * 32'd32) & 32'hFFFF)
           + (32'(op.pixel_y) % 8) * 4 + (x % 8) / 2) & 32'hFFFF;
    addr = 16'(sum % VRAM_BYTES);
    hi   = (x[0] == 1'b0);
  endfunction

  // Perform one access on the shadow memory; return the color the block should report.
  function automatic logic [3:0] apply_pixel_access(input pixel_op_t op);
    logic [15:0] addr;
    logic        hi;
    locate_pixel(op, addr, hi);
    if (op.action == ACT_READ) return hi ? vram_shadow[addr][7:4] : vram_shadow[addr][3:0];
    if (hi) vram_shadow[addr][7:4] = op.color;
    else vram_shadow[addr][3:0] = op.color;
    nibble_written[{addr, hi}] = 1'b1;
    return 4'h0;
  endfunction

  function automatic bit nibble_is_written(input pixel_op_t op);
    logic [15:0] addr;
    logic        hi;
    locate_pixel(op, addr, hi);
    return nibble_written[{addr, hi}];
  endfunction

  function automatic logic [7:0] random_tile_count();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return 8'($urandom_range(6, 1));
    endcase
  endfunction

  // Offer one pixel op, hold it until the transfer, then record its expected color.
  task automatic send_pixel_op(input pixel_op_t op, input logic typed,
                               input logic [3:0] typed_color);
    pixel_expect_t entry;
    logic [3:0]    predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 21) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push         <= 1'b1;
    in_action       <= op.action;
    in_tile_order   <= op.tile_order;
    in_base_offset  <= op.base_offset;
    in_width_tiles  <= op.width_tiles;
    in_height_tiles <= op.height_tiles;
    in_pixel_x      <= op.pixel_x;
    in_pixel_y      <= op.pixel_y;
    in_color        <= op.color;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predicted   = apply_pixel_access(op);
    entry.seq   = items_sent;
    entry.color = typed ? typed_color : predicted;
    expected_colors.push_back(entry);
    items_sent++;
    if (op.action == ACT_WRITE) begin
      written_ops.push_back(op);
      if (written_ops.size() > HISTORY_DEPTH)
        written_ops.delete($urandom_range(written_ops.size() - 1));
    end
  endtask

  // Drop push and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // Receiver: random pop, one long hold-off, no stalls in the calm window.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (holdoff_go && holdoff_count < HOLDOFF_LEN) begin
      out_pop <= 1'b0;
      holdoff_count <= holdoff_count + 1;
    end else begin
      out_pop <= calm || ($urandom_range(99) >= 21);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_colors.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: read_color %h with nothing pending", out_read_color);
      end else begin
        oldest = expected_colors.pop_front();
        if (out_read_color !== oldest.color) begin
          error_count++;
          if (error_count <= 10)
            $display("item %0d: read_color expected %h, got %h",
                     oldest.seq, oldest.color, out_read_color);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pixel_op_t   obj;
    pixel_op_t   op;
    pixel_op_t   scene_writes [$];
    int unsigned span_x;
    int unsigned span_y;
    int unsigned pick;
    bit          paused_once;

    paused_once     = 1'b0;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_action       = ACT_READ;
    in_tile_order   = ORDER_ROW;
    in_base_offset  = '0;
    in_width_tiles  = '0;
    in_height_tiles = '0;
    in_pixel_x      = '0;
    in_pixel_y      = '0;
    in_color        = '0;
    foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_pixel_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].color);

    // random scenes on one object each, mixed with noise ops
    while (items_sent < TOTAL_ITEMS) begin
      if (!holdoff_go && items_sent >= 400) holdoff_go = 1'b1;
      if (!paused_once && items_sent >= 1000) begin
        drain_results();
        paused_once = 1'b1;
      end
      calm = (items_sent >= 1200 && items_sent < 1450);

      if ($urandom_range(99) < 70) begin
        obj.base_offset  = 16'($urandom);
        obj.tile_order   = 1'($urandom);
        obj.width_tiles  = random_tile_count();
        obj.height_tiles = random_tile_count();
        // let x run past the object width so the subtraction gets exercised
        span_x = (obj.width_tiles == 0) ? 8 : 16 * obj.width_tiles;
        span_y = (obj.height_tiles == 0) ? 8 : 8 * obj.height_tiles;
        scene_writes.delete();
        repeat ($urandom_range(24, 8)) begin
          op         = obj;
          op.color   = 4'($urandom);
          op.pixel_x = ($urandom_range(5) == 0) ? 12'($urandom) : 12'($urandom_range(span_x - 1));
          op.pixel_y = ($urandom_range(5) == 0) ? 11'($urandom) : 11'($urandom_range(span_y - 1));
          op.action  = (scene_writes.size() == 0 || $urandom_range(99) < 55) ?
                       ACT_WRITE : ACT_READ;
          // revisit the last written byte back to back, same nibble or its neighbor
          if (scene_writes.size() != 0 && $urandom_range(4) == 0) begin
            op.pixel_x = scene_writes[$].pixel_x ^ 12'($urandom_range(1));
            op.pixel_y = scene_writes[$].pixel_y;
          end
          // reads must land on a written nibble: fall back to a pixel of this scene
          if (op.action == ACT_READ && !nibble_is_written(op)) begin
            pick       = $urandom_range(scene_writes.size() - 1);
            op.pixel_x = scene_writes[pick].pixel_x;
            op.pixel_y = scene_writes[pick].pixel_y;
          end
          send_pixel_op(op, 1'b0, 4'h0);
          if (op.action == ACT_WRITE) scene_writes.push_back(op);
        end
      end else begin
        op.action       = ($urandom_range(2) == 0 && written_ops.size() != 0) ?
                          ACT_READ : ACT_WRITE;
        op.tile_order   = 1'($urandom);
        op.base_offset  = 16'($urandom);
        op.width_tiles  = 8'($urandom);
        op.height_tiles = 8'($urandom);
        op.pixel_x      = 12'($urandom);
        op.pixel_y      = 11'($urandom);
        op.color        = 4'($urandom);
        // replay the geometry of an earlier write when the random read hits blank memory
        if (op.action == ACT_READ && !nibble_is_written(op)) begin
          op        = written_ops[$urandom_range(written_ops.size() - 1)];
          op.action = ACT_READ;
          op.color  = 4'($urandom);
        end
        send_pixel_op(op, 1'b0, 4'h0);
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
